FILE: rtl/csblit_pkg.sv
// Shared types and constants for the clipped sprite blitter.
`default_nettype none

package csblit_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned DIM_W       = 12;
  localparam int unsigned POS_W       = 13;
  localparam int unsigned COORD_W     = 15;
  localparam int unsigned ADDR_W      = 22;
  localparam int unsigned COLOR_W     = 16;
  localparam int unsigned ALIGN_W     = 2;
  localparam int unsigned PROD_W      = 2 * DIM_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_ANCHOR_X      = 3'd4,
    REG_ANCHOR_Y      = 3'd5,
    REG_ALIGN_MODE    = 3'd6,
    REG_COLOR_MASK    = 3'd7
  } cfg_reg_t;

  localparam logic [ALIGN_W-1:0] ALIGN_LEFT = 2'd0;
  localparam logic [ALIGN_W-1:0] ALIGN_MID  = 2'd1;
  localparam logic [ALIGN_W-1:0] ALIGN_END  = 2'd2;

  typedef struct packed {
    logic               write_enable;
    logic [DIM_W-1:0]   sx;
    logic [DIM_W-1:0]   sy;
    logic [COLOR_W-1:0] color;
    logic               last;
  } blit_stage_t;

endpackage

`default_nettype wire

FILE: rtl/clipped_sprite_blit.sv
// Chroma-key sprite blitter with alignment and screen clipping, two register stages.
//
//   Port group   Dir  Handshake          Payload
//   cfg_         in   cfg_write_enable   cfg_index, cfg_data
//   in_          in   in_valid/in_stall  in_pixel_color
//   out_         out  out_valid/out_stall out_write_enable, out_write_address,
//                                         out_write_color, out_last_pixel
//
// One word per clock unless the output stalls; words pass stage one, then stage two.
// Stage one clamps counters, aligns, clips and keys; stage two does the row multiply.
// Reset (synchronous, rst_n low) clears counters and valids, loads register defaults.
// A stall on the output holds both stages; a stage that is empty still takes a word.
`default_nettype none

module clipped_sprite_blit #(
  parameter int unsigned MAX_DIM   = 2048,
  parameter int unsigned KEY_COLOR = 63519
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_write_enable,
  input  wire logic [csblit_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [csblit_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [csblit_pkg::COLOR_W-1:0]         in_pixel_color,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic                                        out_write_enable,
  output logic [csblit_pkg::ADDR_W-1:0]               out_write_address,
  output logic [csblit_pkg::COLOR_W-1:0]              out_write_color,
  output logic                                        out_last_pixel
);

  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned POS_W = csblit_pkg::POS_W;
  localparam int unsigned DIM_W = csblit_pkg::DIM_W;
  localparam int unsigned COORD_W = csblit_pkg::COORD_W;
  localparam int unsigned ADDR_W = csblit_pkg::ADDR_W;
  localparam int unsigned COLOR_W = csblit_pkg::COLOR_W;
  localparam int unsigned PROD_W = csblit_pkg::PROD_W;
  localparam logic [POS_W-1:0] MAX_DIM_V = POS_W'(MAX_DIM);
  localparam logic [COLOR_W-1:0] KEY_V = COLOR_W'(KEY_COLOR);

  logic [DIM_W-1:0]                   scr_w_r, scr_h_r, spr_w_r, spr_h_r;
  logic signed [POS_W-1:0]            anchor_x_r, anchor_y_r;
  logic [csblit_pkg::ALIGN_W-1:0]     align_r;
  logic [COLOR_W-1:0]                 mask_r;

  logic [CNT_W-1:0]                   col_cnt_r, row_cnt_r, col_cnt_nxt, row_cnt_nxt;
  logic                               s1_valid_r, s1_valid_nxt;
  csblit_pkg::blit_stage_t            s1_r, s1_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_we_r, out_last_r;
  logic [ADDR_W-1:0]                  out_addr_r, out_addr_nxt;
  logic [COLOR_W-1:0]                 out_color_r;

  logic                               out_ready, s1_ready, in_accept;
  logic [POS_W-1:0]                   w_eff, h_eff, w_last, h_last, offset;
  logic [CNT_W-1:0]                   col, row;
  logic                               col_end, row_end, visible;
  logic signed [COORD_W-1:0]          x_pos, sx, sy;
  logic [PROD_W-1:0]                  row_base, addr_sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r    <= DIM_W'(1024);
      scr_h_r    <= DIM_W'(768);
      spr_w_r    <= DIM_W'(1);
      spr_h_r    <= DIM_W'(1);
      anchor_x_r <= '0;
      anchor_y_r <= '0;
      align_r    <= csblit_pkg::ALIGN_LEFT;
      mask_r     <= '1;
    end else if (cfg_write_enable) begin
      unique case (csblit_pkg::cfg_reg_t'(cfg_index))
        csblit_pkg::REG_SCREEN_WIDTH:  scr_w_r    <= cfg_data[DIM_W-1:0];
        csblit_pkg::REG_SCREEN_HEIGHT: scr_h_r    <= cfg_data[DIM_W-1:0];
        csblit_pkg::REG_SPRITE_WIDTH:  spr_w_r    <= cfg_data[DIM_W-1:0];
        csblit_pkg::REG_SPRITE_HEIGHT: spr_h_r    <= cfg_data[DIM_W-1:0];
        csblit_pkg::REG_ANCHOR_X:      anchor_x_r <= $signed(cfg_data[POS_W-1:0]);
        csblit_pkg::REG_ANCHOR_Y:      anchor_y_r <= $signed(cfg_data[POS_W-1:0]);
        csblit_pkg::REG_ALIGN_MODE:    align_r    <= cfg_data[csblit_pkg::ALIGN_W-1:0];
        csblit_pkg::REG_COLOR_MASK:    mask_r     <= cfg_data[COLOR_W-1:0];
        default:                       mask_r     <= mask_r;
      endcase
    end
  end

  // handshake
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;

  // stage one: clamp counters, align, clip, colour key and mask
  always_comb begin
    if (spr_w_r == '0) begin
      w_eff = POS_W'(1);
    end else if (POS_W'(spr_w_r) > MAX_DIM_V) begin
      w_eff = MAX_DIM_V;
    end else begin
      w_eff = POS_W'(spr_w_r);
    end
    if (spr_h_r == '0) begin
      h_eff = POS_W'(1);
    end else if (POS_W'(spr_h_r) > MAX_DIM_V) begin
      h_eff = MAX_DIM_V;
    end else begin
      h_eff = POS_W'(spr_h_r);
    end
    w_last = w_eff - POS_W'(1);
    h_last = h_eff - POS_W'(1);
    col = (POS_W'(col_cnt_r) < w_eff) ? col_cnt_r : w_last[CNT_W-1:0];
    row = (POS_W'(row_cnt_r) < h_eff) ? row_cnt_r : h_last[CNT_W-1:0];
    col_end = (POS_W'(col) == w_last);
    row_end = (POS_W'(row) == h_last);

    if (col_end) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = row_end ? '0 : row + CNT_W'(1);
    end else begin
      col_cnt_nxt = col + CNT_W'(1);
      row_cnt_nxt = row;
    end

    unique case (align_r)
      csblit_pkg::ALIGN_LEFT: offset = '0;
      csblit_pkg::ALIGN_MID:  offset = w_eff >> 1;
      csblit_pkg::ALIGN_END:  offset = w_eff;
      default:                offset = '0;
    endcase

    x_pos = $signed({{(COORD_W-POS_W){anchor_x_r[POS_W-1]}}, anchor_x_r})
          - $signed(COORD_W'(offset));
    sx = x_pos + $signed(COORD_W'(col));
    sy = $signed({{(COORD_W-POS_W){anchor_y_r[POS_W-1]}}, anchor_y_r})
       + $signed(COORD_W'(h_last)) - $signed(COORD_W'(row));

    visible = !sx[COORD_W-1] && (sx < $signed(COORD_W'(scr_w_r)))
           && !sy[COORD_W-1] && (sy < $signed(COORD_W'(scr_h_r)));

    s1_nxt.write_enable = visible && (in_pixel_color != KEY_V);
    s1_nxt.sx           = sx[DIM_W-1:0];
    s1_nxt.sy           = sy[DIM_W-1:0];
    s1_nxt.color        = s1_nxt.write_enable ? (in_pixel_color & mask_r) : '0;
    s1_nxt.last         = col_end && row_end;

    s1_valid_nxt = s1_ready ? in_valid : s1_valid_r;
  end

  // stage two: frame-buffer address
  always_comb begin
    row_base      = PROD_W'(s1_r.sy) * PROD_W'(scr_w_r);
    addr_sum      = row_base + PROD_W'(s1_r.sx);
    out_addr_nxt  = s1_r.write_enable ? addr_sum[ADDR_W-1:0] : '0;
    out_valid_nxt = out_ready ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= s1_nxt;
    end
    if (out_ready && s1_valid_r) begin
      out_we_r    <= s1_r.write_enable;
      out_addr_r  <= out_addr_nxt;
      out_color_r <= s1_r.color;
      out_last_r  <= s1_r.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_enable  = out_we_r;
  assign out_write_address = out_addr_r;
  assign out_write_color   = out_color_r;
  assign out_last_pixel    = out_last_r;

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && s1_nxt.last) |=> (col_cnt_r == '0 && row_cnt_r == '0))
    else $error("counters did not wrap after last pixel");

  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_we_r) |-> (out_addr_r == '0 && out_color_r == '0))
    else $error("disabled write carries nonzero payload");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_ready) |=> out_valid_r)
    else $error("stage one word lost on advance");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free stage");

endmodule

`default_nettype wire
